### hdl/gnte_pkg.sv
`default_nettype none

package gnte_pkg;

    localparam int TT_W          = 64;                    // truth table width
    localparam int TT_VARS       = 6;                     // variables in one table
    localparam int TABLE_SLOTS   = 1024;                  // power of two
    localparam int ADDR_W        = $clog2(TABLE_SLOTS);
    localparam int SLOT_W        = 10;                    // slot field width on the port
    localparam int MAX_FANIN     = 5;
    localparam int FANIN_FIELDS  = 5;
    localparam int FANIN_LIMIT   = (MAX_FANIN < FANIN_FIELDS) ? MAX_FANIN : FANIN_FIELDS;
    localparam int CNT_W         = 3;                     // fanin count field width
    localparam int VAR_W         = 3;
    localparam int FUNC_W        = 4;
    localparam int VIDX_W        = $clog2(TT_VARS);

    typedef enum logic [FUNC_W-1:0] {
        FN_ZERO = 4'd0,
        FN_ONE  = 4'd1,
        FN_NOP  = 4'd2,
        FN_IN   = 4'd3,
        FN_OUT  = 4'd4,
        FN_NOT  = 4'd5,
        FN_AND  = 4'd6,
        FN_OR   = 4'd7,
        FN_XOR  = 4'd8,
        FN_NAND = 4'd9,
        FN_NOR  = 4'd10,
        FN_XNOR = 4'd11,
        FN_MAJ  = 4'd12
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]                    func;
        logic [SLOT_W-1:0]                    gate_slot;
        logic                                 source_flag;
        logic [VAR_W-1:0]                     var_index;
        logic                                 target_flag;
        logic [CNT_W-1:0]                     fanin_count;
        logic [FANIN_FIELDS-1:0][SLOT_W-1:0]  fanin_slot;
        logic                                 last_gate;
    } t_item;

    // controller -> datapath
    typedef struct packed {
        logic             load;     // capture the incoming item
        logic             rd_en;    // fetch one fanin table
        logic [CNT_W-1:0] rd_idx;   // which fanin
        logic             eval;     // compute, write back, load result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [CNT_W-1:0] in_reads; // fanin fetches the offered item needs
    } t_sts;

    function automatic logic [ADDR_W-1:0] slot_addr(logic [SLOT_W-1:0] slot);
        return ADDR_W'(slot);
    endfunction

    function automatic logic gate_bad(logic [FUNC_W-1:0] func, logic [CNT_W-1:0] n);
        logic bad;
        bad = 1'b0;
        if (func > FN_MAJ || n > CNT_W'(FANIN_LIMIT)) begin
            bad = 1'b1;
        end else if (func >= FN_NOP && func <= FN_NOT) begin
            bad = (n != CNT_W'(1));
        end else if (func >= FN_AND) begin
            bad = (n == '0);
        end
        return bad;
    endfunction

    function automatic logic [CNT_W-1:0] read_count(t_item it);
        logic [CNT_W-1:0] n;
        n = it.fanin_count;
        if (it.source_flag || gate_bad(it.func, it.fanin_count) || it.func <= FN_ONE) begin
            n = '0;
        end
        return n;
    endfunction

    // bit i of the table is bit v of i; zero for v outside the variables
    function automatic logic [TT_W-1:0] proj_pattern(logic [VAR_W-1:0] v);
        logic [TT_W-1:0]   t;
        logic [TT_VARS-1:0] ib;
        t = '0;
        for (int i = 0; i < TT_W; i++) begin
            ib = TT_VARS'(i);
            if (v < VAR_W'(TT_VARS)) begin
                t[i] = ib[VIDX_W'(v)];
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

### hdl/gnte_in_if.sv
`default_nettype none

interface gnte_in_if
    import gnte_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [SLOT_W-1:0]        gate_slot;
    logic                     source_flag;
    logic [VAR_W-1:0]         var_index;
    logic                     target_flag;
    logic [CNT_W-1:0]         fanin_count;
    logic [SLOT_W-1:0]        fanin_slot_a;
    logic [SLOT_W-1:0]        fanin_slot_b;
    logic [SLOT_W-1:0]        fanin_slot_c;
    logic [SLOT_W-1:0]        fanin_slot_d;
    logic [SLOT_W-1:0]        fanin_slot_e;
    logic                     last_gate;

    modport source (
        output valid, func, gate_slot, source_flag, var_index, target_flag,
               fanin_count, fanin_slot_a, fanin_slot_b, fanin_slot_c,
               fanin_slot_d, fanin_slot_e, last_gate,
        input  ready
    );

    modport sink (
        input  valid, func, gate_slot, source_flag, var_index, target_flag,
               fanin_count, fanin_slot_a, fanin_slot_b, fanin_slot_c,
               fanin_slot_d, fanin_slot_e, last_gate,
        output ready
    );
endinterface

`default_nettype wire

### hdl/gnte_out_if.sv
`default_nettype none

interface gnte_out_if
    import gnte_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [TT_W-1:0] node_table;
    logic [TT_W-1:0] target_table;
    logic            unsupported;

    modport source (
        output valid, node_table, target_table, unsupported,
        input  ready
    );

    modport sink (
        input  valid, node_table, target_table, unsupported,
        output ready
    );
endinterface

`default_nettype wire

### hdl/gnte_ctrl.sv
`default_nettype none

module gnte_ctrl
    import gnte_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_reads, n_reads;
    logic             r_out_vld, n_out_vld;
    logic             out_free;
    logic             last_rd;

    assign out_free = !r_out_vld || i_out_ready;
    assign last_rd  = (r_cnt == CNT_W'(r_reads - CNT_W'(1)));

    // outputs
    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.eval   = 1'b0;
        o_cmd.rd_idx = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;    // nothing taken while held in reset
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_EVAL: begin
                o_cmd.eval = out_free;
                o_in_ready = out_free;   // next item enters as this one retires
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.load  = i_in_valid && o_in_ready;
        o_out_valid = r_out_vld;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state = (i_sts.in_reads != '0) ? ST_READ : ST_EVAL;
                end
            end
            ST_READ: begin
                if (last_rd) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (o_cmd.load) begin
                    n_state = (i_sts.in_reads != '0) ? ST_READ : ST_EVAL;
                end else if (o_cmd.eval) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cnt     = r_cnt;
        n_reads   = r_reads;
        n_out_vld = r_out_vld;
        if (o_cmd.load) begin
            n_cnt   = '0;
            n_reads = i_sts.in_reads;
        end else if (o_cmd.rd_en) begin
            n_cnt = CNT_W'(r_cnt + CNT_W'(1));
        end
        if (o_cmd.eval) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_reads   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_reads   <= n_reads;
            r_out_vld <= n_out_vld;
        end
    end

`ifndef SYNTHESIS
    a_eval_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.eval |-> (!r_out_vld || i_out_ready))
        else $error("result overwritten while stalled");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_cnt < r_reads))
        else $error("fanin fetch beyond count");

    a_read_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && last_rd) |=> (r_state == ST_EVAL))
        else $error("missed evaluation after last fetch");

    a_valid_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(o_cmd.eval))
        else $error("result valid without evaluation");
`endif

endmodule

`default_nettype wire

### hdl/gnte_dp.sv
`default_nettype none

module gnte_dp
    import gnte_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_item i_item,
    input  wire t_cmd  i_cmd,
    output t_sts       o_sts,
    output logic [TT_W-1:0] o_node_table,
    output logic [TT_W-1:0] o_target_table,
    output logic            o_unsupported
);

    logic [TT_W-1:0] r_mem [TABLE_SLOTS];
    logic [TT_W-1:0] r_fan [FANIN_FIELDS];
    t_item           r_item;
    logic [TT_W-1:0] r_held;
    logic [TT_W-1:0] r_node;
    logic [TT_W-1:0] r_tgt;
    logic            r_unsup;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [TT_W-1:0]   acc_and, acc_or, acc_xor, maj;
    logic [CNT_W-1:0]  bit_cnt;
    logic [TT_W-1:0]   fn_table;
    logic [TT_W-1:0]   n_table;
    logic              bad;

    assign o_sts.in_reads = read_count(i_item);
    assign rd_addr = slot_addr(r_item.fanin_slot[i_cmd.rd_idx]);
    assign wr_addr = slot_addr(r_item.gate_slot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    // single-port table store: fetch during reads, write at evaluation
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_mem[wr_addr] <= n_table;
        end else if (i_cmd.rd_en) begin
            r_fan[i_cmd.rd_idx] <= r_mem[rd_addr];
        end
    end

    // folds over the used lanes only
    always_comb begin
        acc_and = '1;
        acc_or  = '0;
        acc_xor = '0;
        for (int l = 0; l < FANIN_FIELDS; l++) begin
            if (CNT_W'(l) < r_item.fanin_count) begin
                acc_and = acc_and & r_fan[l];
                acc_or  = acc_or  | r_fan[l];
                acc_xor = acc_xor ^ r_fan[l];
            end
        end
    end

    // strict majority per bit
    always_comb begin
        maj     = '0;
        bit_cnt = '0;
        for (int b = 0; b < TT_W; b++) begin
            bit_cnt = '0;
            for (int l = 0; l < FANIN_FIELDS; l++) begin
                if (CNT_W'(l) < r_item.fanin_count) begin
                    bit_cnt = CNT_W'(bit_cnt + CNT_W'(r_fan[l][b]));
                end
            end
            maj[b] = ({bit_cnt, 1'b0} > {1'b0, r_item.fanin_count});
        end
    end

    always_comb begin
        unique case (r_item.func)
            FN_ZERO:                fn_table = '0;
            FN_ONE:                 fn_table = '1;
            FN_NOP, FN_IN, FN_OUT:  fn_table = r_fan[0];
            FN_NOT:                 fn_table = ~r_fan[0];
            FN_AND:                 fn_table = acc_and;
            FN_OR:                  fn_table = acc_or;
            FN_XOR:                 fn_table = acc_xor;
            FN_NAND:                fn_table = ~acc_and;
            FN_NOR:                 fn_table = ~acc_or;
            FN_XNOR:                fn_table = ~acc_xor;
            FN_MAJ: begin
                if (r_item.fanin_count == CNT_W'(1)) begin
                    fn_table = r_fan[0];
                end else if (r_item.fanin_count == CNT_W'(3) ||
                             r_item.fanin_count == CNT_W'(5)) begin
                    fn_table = maj;
                end else begin
                    fn_table = acc_and;
                end
            end
            default:                fn_table = '0;
        endcase
    end

    always_comb begin
        bad = !r_item.source_flag && gate_bad(r_item.func, r_item.fanin_count);
        if (r_item.source_flag) begin
            n_table = proj_pattern(r_item.var_index);
        end else if (bad) begin
            n_table = '0;
        end else begin
            n_table = fn_table;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_node  <= n_table;
            r_unsup <= bad;
            r_tgt   <= r_item.target_flag ? n_table : r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.eval) begin
            if (r_item.last_gate) begin
                r_held <= '0;
            end else if (r_item.target_flag) begin
                r_held <= n_table;
            end
        end
    end

    assign o_node_table   = r_node;
    assign o_target_table = r_tgt;
    assign o_unsupported  = r_unsup;

endmodule

`default_nettype wire

### hdl/gate_net_truth_table_evaluator_top.sv
// Gate net truth table evaluator.
// Gates of a net arrive one per beat on i_in, in topological order. Each
// gate's 64-bit table is computed and written to its slot of a 1024-entry
// single-port table store; fanin tables are fetched from slots written by
// earlier beats. Each input beat gives exactly one result beat on o_out:
// the gate's table, the table of the latest target gate of the net (zero if
// none) and an unsupported flag for a bad function code or fanin count.
// Sequencing: a gate that needs k fanin tables (k = 0..5; source, zero,
// one and unsupported gates need none) fetches them one per cycle on the
// store's one port, then evaluates and writes its table back. The next
// gate is accepted in the evaluation cycle.
// Results sit in an output register; while the receiver stalls, one result
// waits there, the next gate is held in evaluation and none is accepted.
// Reset (i_rst_n low, synchronous) clears the controller, the output valid
// and the held target table. The table store is not cleared; a slot must be
// written before any gate reads it. The held target is cleared after the
// beat that carries last_gate.
`default_nettype none

module gate_net_truth_table_evaluator_top
    import gnte_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gnte_in_if.sink   i_in,
    gnte_out_if.source o_out
);

    t_item item;
    t_cmd  cmd;
    t_sts  sts;

    // gather the input beat into one record
    always_comb begin
        item.func          = i_in.func;
        item.gate_slot     = i_in.gate_slot;
        item.source_flag   = i_in.source_flag;
        item.var_index     = i_in.var_index;
        item.target_flag   = i_in.target_flag;
        item.fanin_count   = i_in.fanin_count;
        item.fanin_slot[0] = i_in.fanin_slot_a;
        item.fanin_slot[1] = i_in.fanin_slot_b;
        item.fanin_slot[2] = i_in.fanin_slot_c;
        item.fanin_slot[3] = i_in.fanin_slot_d;
        item.fanin_slot[4] = i_in.fanin_slot_e;
        item.last_gate     = i_in.last_gate;
    end

    // sequencing: fetch count, evaluation slot, output valid
    gnte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // table store, fanin registers, gate functions, result register
    gnte_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (item),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_node_table   (o_out.node_table),
        .o_target_table (o_out.target_table),
        .o_unsupported  (o_out.unsupported)
    );

endmodule

`default_nettype wire
